// ----- rtl/sdmm_pkg.sv -----
// Shared constants, controller state type and control structs for the strip deduplicator.
package sdmm_pkg;

   localparam int MAX_STRIPS_DEF  = 256;
   localparam int STRIP_UNITS_DEF = 32;
   localparam int UNIT_W          = 8;
   localparam int LABEL_OUT_W     = 8;
   localparam int USED_W          = 6;
   localparam int FLAG_W          = 3;
   localparam logic [USED_W-1:0] USED_RESET = USED_W'(32);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic take;
      logic prep;
      logic scan;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic complete;
      logic hit;
      logic scan_done;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/strip_dedup_with_mirror_match.sv -----
// Top level of the strip deduplicator with forward and mirrored matching.
//
//   Channel  Direction  Payload
//   req_     in         tdata[7:0] unit, tuser start_image
//   rsp_     out        tdata[7:0] strip_label, tuser flipped / is_new / table_full
//   csr_     in         data[5:0] used_units
//
// A unit that does not complete a strip is taken without holding the input.
// A unit that completes a strip is taken; the input is then held through the prepare, scan and
// finish states, and the store RAM is read one strip per cycle on its single read port.
// Reset clears the counters and valid flags and sets used_units to 32; the store holds no valid
// data until written and needs no clearing pass.
// Units keep being taken while a result waits in the output register; a completed strip waits
// until that register is free.
module strip_dedup_with_mirror_match import sdmm_pkg::*; #(
   parameter int MAX_STRIPS  = MAX_STRIPS_DEF,
   parameter int STRIP_UNITS = STRIP_UNITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [UNIT_W-1:0]      req_tdata,   // [7:0] unit
   input  logic                   req_tuser,   // [0] start_image
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [LABEL_OUT_W-1:0] rsp_tdata,   // [7:0] strip_label
   output logic [FLAG_W-1:0]      rsp_tuser,   // [0] flipped, [1] is_new, [2] table_full
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [USED_W-1:0]      csr_data
);

   cmd_type    cmd;
   status_type status;

   sdmm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   sdmm_datapath #(
      .MAX_STRIPS  (MAX_STRIPS),
      .STRIP_UNITS (STRIP_UNITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   assign req_tready = cmd.take;
   assign csr_ready  = 1'b1;

endmodule

// ----- rtl/sdmm_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module sdmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sdmm_ctrl.sv -----
// Controller state machine that sequences strip collection, store search and result hand-off.
module sdmm_ctrl import sdmm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (status.complete) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.hit || status.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take = 1'b1;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_FINISH: begin
            cmd.load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- rtl/sdmm_datapath.sv -----
// Datapath: strip collection, reversed copy, store search pipeline, store write and result register.
module sdmm_datapath import sdmm_pkg::*; #(
   parameter int MAX_STRIPS  = MAX_STRIPS_DEF,
   parameter int STRIP_UNITS = STRIP_UNITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic                   req_tvalid,
   input  logic [UNIT_W-1:0]      req_tdata,
   input  logic                   req_tuser,
   input  logic                   csr_valid,
   input  logic [USED_W-1:0]      csr_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [LABEL_OUT_W-1:0] rsp_tdata,
   output logic [FLAG_W-1:0]      rsp_tuser
);

   localparam int IDX_W  = $clog2(STRIP_UNITS);
   localparam int CNT_W  = $clog2(STRIP_UNITS + 1);
   localparam int LBL_W  = $clog2(MAX_STRIPS);
   localparam int DCNT_W = $clog2(MAX_STRIPS + 1);
   localparam int ROW_W  = STRIP_UNITS * UNIT_W;

   logic [USED_W-1:0]      used_ff, used_in;
   logic [UNIT_W-1:0]      pend_ff [STRIP_UNITS];
   logic [UNIT_W-1:0]      pend_in [STRIP_UNITS];
   logic [UNIT_W-1:0]      rev_ff [STRIP_UNITS];
   logic [UNIT_W-1:0]      rev_in [STRIP_UNITS];
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       base, count_next, len, src;
   logic [USED_W:0]        used_x, len_x;
   logic [DCNT_W-1:0]      dcount_ff, dcount_in;
   logic [DCNT_W-1:0]      rd_lbl_ff, rd_lbl_in;
   logic                   cmp_valid_ff, cmp_valid_in;
   logic [LBL_W-1:0]       cmp_lbl_ff, cmp_lbl_in;
   logic [LBL_W-1:0]       res_lbl_ff, res_lbl_in;
   logic                   res_flip_ff, res_flip_in;
   logic                   res_new_ff, res_new_in;
   logic                   res_full_ff, res_full_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LABEL_OUT_W-1:0] rsp_lbl_ff, rsp_lbl_in;
   logic [FLAG_W-1:0]      rsp_user_ff, rsp_user_in;
   logic [LBL_W+LABEL_OUT_W-1:0] lbl_ext;
   logic [STRIP_UNITS-1:0] mask;
   logic                   fire, issue, fwd, rvs, full, wr_en;
   logic [ROW_W-1:0]       rd_data, wr_data;

   assign fire = req_tvalid & cmd.take;

   always_comb begin
      used_x = {1'b0, used_ff};
      if (used_ff == '0) begin
         len_x = (USED_W + 1)'(1);
      end else if (used_x > (USED_W + 1)'(STRIP_UNITS)) begin
         len_x = (USED_W + 1)'(STRIP_UNITS);
      end else begin
         len_x = used_x;
      end
      len = CNT_W'(len_x);
      for (int k = 0; k < STRIP_UNITS; k++) begin
         mask[k] = CNT_W'(k) < len;
      end
   end

   always_comb begin
      used_in = csr_valid ? csr_data : used_ff;
      base       = req_tuser ? '0 : count_ff;
      count_next = base + CNT_W'(1);
      count_in   = count_ff;
      pend_in    = pend_ff;
      if (fire) begin
         pend_in[base[IDX_W-1:0]] = req_tdata;
         count_in = (count_next >= len) ? '0 : count_next;
      end
   end

   always_comb begin
      rev_in = rev_ff;
      src    = '0;
      if (cmd.prep) begin
         for (int k = 0; k < STRIP_UNITS; k++) begin
            src = len - CNT_W'(1) - CNT_W'(k);
            rev_in[k] = mask[k] ? pend_ff[src[IDX_W-1:0]] : '0;
         end
      end
   end

   always_comb begin
      issue        = cmd.scan && (rd_lbl_ff < dcount_ff);
      rd_lbl_in    = rd_lbl_ff;
      cmp_valid_in = 1'b0;
      cmp_lbl_in   = rd_lbl_ff[LBL_W-1:0];
      if (cmd.prep) begin
         rd_lbl_in = '0;
      end else if (issue) begin
         rd_lbl_in    = rd_lbl_ff + DCNT_W'(1);
         cmp_valid_in = 1'b1;
      end
   end

   always_comb begin
      fwd = 1'b1;
      rvs = 1'b1;
      for (int k = 0; k < STRIP_UNITS; k++) begin
         if (mask[k] && (rd_data[k*UNIT_W +: UNIT_W] != pend_ff[k])) begin
            fwd = 1'b0;
         end
         if (mask[k] && (rd_data[k*UNIT_W +: UNIT_W] != rev_ff[k])) begin
            rvs = 1'b0;
         end
      end
      for (int k = 0; k < STRIP_UNITS; k++) begin
         wr_data[k*UNIT_W +: UNIT_W] = mask[k] ? pend_ff[k] : '0;
      end
   end

   assign full = (dcount_ff == DCNT_W'(MAX_STRIPS));

   always_comb begin
      status.complete  = fire && (count_next >= len);
      status.hit       = cmp_valid_ff && (fwd || rvs);
      status.scan_done = !cmp_valid_ff && (rd_lbl_ff >= dcount_ff);
      status.out_free  = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      res_lbl_in  = res_lbl_ff;
      res_flip_in = res_flip_ff;
      res_new_in  = res_new_ff;
      res_full_in = res_full_ff;
      dcount_in   = dcount_ff;
      wr_en       = 1'b0;
      if (fire && req_tuser) begin
         dcount_in = '0;
      end
      if (cmd.scan) begin
         if (status.hit) begin
            res_lbl_in  = cmp_lbl_ff;
            res_flip_in = !fwd;
            res_new_in  = 1'b0;
            res_full_in = 1'b0;
         end else if (status.scan_done) begin
            res_flip_in = 1'b0;
            if (full) begin
               res_lbl_in  = '0;
               res_new_in  = 1'b0;
               res_full_in = 1'b1;
            end else begin
               wr_en       = 1'b1;
               res_lbl_in  = dcount_ff[LBL_W-1:0];
               res_new_in  = 1'b1;
               res_full_in = 1'b0;
               dcount_in   = dcount_ff + DCNT_W'(1);
            end
         end
      end
   end

   assign lbl_ext = (LBL_W + LABEL_OUT_W)'(res_lbl_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_lbl_in   = rsp_lbl_ff;
      rsp_user_in  = rsp_user_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
         rsp_lbl_in   = lbl_ext[LABEL_OUT_W-1:0];
         rsp_user_in  = {res_full_ff, res_new_ff, res_flip_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= USED_RESET;
         count_ff     <= '0;
         dcount_ff    <= '0;
         rd_lbl_ff    <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         count_ff     <= count_in;
         dcount_ff    <= dcount_in;
         rd_lbl_ff    <= rd_lbl_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rev_ff      <= rev_in;
      cmp_lbl_ff  <= cmp_lbl_in;
      res_lbl_ff  <= res_lbl_in;
      res_flip_ff <= res_flip_in;
      res_new_ff  <= res_new_in;
      res_full_ff <= res_full_in;
      rsp_lbl_ff  <= rsp_lbl_in;
      rsp_user_ff <= rsp_user_in;
   end

   sdmm_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_STRIPS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (dcount_ff[LBL_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (rd_lbl_ff[LBL_W-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_lbl_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- rtl/sdmm_checker.sv -----
// Port-level checker for the strip deduplicator, bound to the top level.
module sdmm_checker import sdmm_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [LABEL_OUT_W-1:0] rsp_tdata,
   input logic [FLAG_W-1:0]      rsp_tuser
);

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> (rsp_tdata == '0) && !rsp_tuser[1] && !rsp_tuser[0])
      else $error("Full-table transfer carries a label or other flags.");

   a_new_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0] && !rsp_tuser[2])
      else $error("New-strip transfer is also flagged as flipped or full.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled result transfer changed or was withdrawn.");

   a_ready_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("Pending result was lost while a unit was taken.");

endmodule

bind strip_dedup_with_mirror_match sdmm_checker u_sdmm_checker (.*);

// ----- bench/strip_dedup_with_mirror_match_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the strip deduplicator: directed strips, a full store, then random strips.
module strip_dedup_with_mirror_match_tb;
   import sdmm_pkg::*;

   localparam int STORE_DEPTH   = MAX_STRIPS_DEF;
   localparam int STRIP_SLOTS   = STRIP_UNITS_DEF;
   localparam int SETTLE_CYCLES = MAX_STRIPS_DEF + 40;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int RANDOM_UNITS  = 480;
   localparam int RANDOM_PHASES = 12;

   typedef enum int {SINK_ALWAYS, SINK_RANDOM, SINK_SPARSE, SINK_BURSTY} sink_mode_type;

   typedef struct packed {
      logic [LABEL_OUT_W-1:0] label;
      logic                   flipped;
      logic                   is_new;
      logic                   table_full;
   } strip_verdict_type;

   typedef logic [STRIP_UNITS_DEF-1:0][UNIT_W-1:0] strip_bits_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [UNIT_W-1:0]      req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [LABEL_OUT_W-1:0] rsp_tdata;
   logic [FLAG_W-1:0]      rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [USED_W-1:0]      csr_data = '0;

   sink_mode_type sink_mode = SINK_ALWAYS;
   logic [7:0]    sink_tick = '0;
   bit            steady_sender = 1'b1;
   int            burst_left = 1;
   int unsigned   cycle_count = 0;
   int            mismatch_count = 0;

   logic [UNIT_W-1:0] distinct_units [STORE_DEPTH][STRIP_SLOTS];
   logic [UNIT_W-1:0] pending_units [STRIP_SLOTS];
   int                held_units = 0;
   int                stored_strips = 0;
   logic [USED_W-1:0] strip_setting = USED_RESET;
   strip_verdict_type awaited_verdicts [$];

   strip_dedup_with_mirror_match uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int strip_length(logic [USED_W-1:0] setting);
      if (setting == 0) return 1;
      if (setting > STRIP_SLOTS) return STRIP_SLOTS;
      return int'(setting);
   endfunction

   function automatic bit strip_matches(int label, int len, bit mirrored);
      int src;
      for (int k = 0; k < len; k++) begin
         src = mirrored ? len - 1 - k : k;
         if (pending_units[src] != distinct_units[label][k]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void predict_unit(logic [UNIT_W-1:0] unit_value, logic start_image);
      int len;
      strip_verdict_type verdict;
      if (start_image) begin
         stored_strips = 0;
         held_units = 0;
      end
      if (held_units < STRIP_SLOTS) pending_units[held_units] = unit_value;
      held_units++;
      len = strip_length(strip_setting);
      if (held_units < len) return;
      held_units = 0;
      verdict = '0;
      for (int label = 0; label < stored_strips; label++) begin
         for (int mirrored = 0; mirrored < 2; mirrored++) begin
            if (strip_matches(label, len, mirrored[0])) begin
               verdict.label   = label[LABEL_OUT_W-1:0];
               verdict.flipped = mirrored[0];
               awaited_verdicts.push_back(verdict);
               return;
            end
         end
      end
      if (stored_strips >= STORE_DEPTH) begin
         verdict.table_full = 1'b1;
      end else begin
         for (int k = 0; k < STRIP_SLOTS; k++)
            distinct_units[stored_strips][k] = (k < len) ? pending_units[k] : '0;
         verdict.label  = stored_strips[LABEL_OUT_W-1:0];
         verdict.is_new = 1'b1;
         stored_strips++;
      end
      awaited_verdicts.push_back(verdict);
   endfunction

   task automatic send_unit(logic [UNIT_W-1:0] unit_value, logic start_image);
      req_tdata  <= unit_value;
      req_tuser  <= start_image;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_unit(unit_value, start_image);
      @(negedge clock);
      if (!steady_sender) begin
         burst_left--;
         if (burst_left <= 0) begin
            req_tvalid <= 1'b0;
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4))
               @(negedge clock);
            burst_left = $urandom_range(1, 24);
         end
      end
   endtask

   task automatic send_strip(strip_bits_type units, int count, logic start_image);
      for (int k = 0; k < count; k++)
         send_unit(units[k], start_image && k == 0);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (awaited_verdicts.size() != 0);
   endtask

   task automatic write_strip_length(logic [USED_W-1:0] setting);
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_data  <= setting;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      strip_setting = setting;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_length();
      strip_bits_type strip;
      sink_mode = SINK_RANDOM;
      for (int k = 0; k < STRIP_SLOTS; k++)
         strip[k] = (k == STRIP_SLOTS - 1) ? 8'hFF : UNIT_W'(k * 8);
      send_strip(strip, STRIP_SLOTS, 1'b1);
   endtask

   task automatic test_mirror_match();
      write_strip_length(USED_W'(3));
      send_strip(strip_bits_type'({8'd3, 8'd2, 8'd1}), 3, 1'b1);
      send_strip(strip_bits_type'({8'd1, 8'd2, 8'd3}), 3, 1'b0);
      send_strip(strip_bits_type'({8'd3, 8'd2, 8'd1}), 3, 1'b0);
      send_strip(strip_bits_type'({8'd5, 8'd7, 8'd5}), 3, 1'b0);
      send_strip(strip_bits_type'({8'd5, 8'd7, 8'd5}), 3, 1'b0);
   endtask

   task automatic test_length_clamp();
      write_strip_length(USED_W'(0));
      send_unit(8'd5, 1'b0);
      send_unit(8'd255, 1'b0);
   endtask

   task automatic test_start_discards_tail();
      write_strip_length(USED_W'(3));
      send_strip(strip_bits_type'({8'd21, 8'd20}), 2, 1'b1);
      send_strip(strip_bits_type'({8'd24, 8'd23, 8'd22}), 3, 1'b1);
   endtask

   task automatic test_length_change_mid_strip();
      write_strip_length(USED_W'(4));
      send_strip(strip_bits_type'({8'd12, 8'd11, 8'd10}), 3, 1'b1);
      write_strip_length(USED_W'(2));
      send_unit(8'd13, 1'b0);
      send_strip(strip_bits_type'({8'd10, 8'd11}), 2, 1'b0);
      write_strip_length(USED_W'(5));
      send_unit(8'd40, 1'b0);
      write_strip_length(USED_W'(1));
      send_unit(8'd41, 1'b0);
   endtask

   task automatic test_table_full();
      write_strip_length(USED_W'(1));
      steady_sender = 1'b0;
      sink_mode = SINK_BURSTY;
      for (int v = 0; v < STORE_DEPTH; v++)
         send_unit(UNIT_W'(v), v == 0);
      write_strip_length(USED_W'(2));
      send_strip(strip_bits_type'({8'd2, 8'd1}), 2, 1'b0);
      send_strip(strip_bits_type'({8'd5, 8'd0}), 2, 1'b0);
      send_strip(strip_bits_type'({8'd0, 8'd5}), 2, 1'b0);
      send_strip(strip_bits_type'({8'd0, 8'd0}), 2, 1'b0);
      send_strip(strip_bits_type'({8'd255, 8'd255}), 2, 1'b0);
   endtask

   task automatic test_random_strips();
      int             settings [RANDOM_PHASES] = '{1, 2, 3, 4, 5, 8, 16, 32, 0, 40, 63, 7};
      strip_bits_type history [$];
      strip_bits_type strip;
      strip_bits_type origin;
      int             sent;
      int             budget;
      int             len;
      int             kind;
      int             count;
      bit             narrow;
      bit             force_start;
      sent = 0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == RANDOM_PHASES - 1)
            write_strip_length(USED_W'($urandom_range(0, 63)));
         else
            write_strip_length(USED_W'(settings[phase]));
         sink_mode = sink_mode_type'($urandom_range(0, 3));
         steady_sender = ($urandom_range(0, 3) == 0);
         budget = sent + RANDOM_UNITS / RANDOM_PHASES;
         len = strip_length(strip_setting);
         force_start = 1'($urandom_range(0, 1));
         while (sent < budget) begin
            kind = $urandom_range(0, 9);
            narrow = 1'($urandom_range(0, 1));
            for (int k = 0; k < STRIP_SLOTS; k++)
               strip[k] = narrow ? UNIT_W'($urandom_range(0, 3))
                                 : UNIT_W'($urandom_range(0, 255));
            if (kind < 3 && history.size() > 0) begin
               strip = history[$urandom_range(0, history.size() - 1)];
            end else if (kind < 6 && history.size() > 0) begin
               origin = history[$urandom_range(0, history.size() - 1)];
               for (int k = 0; k < len; k++)
                  strip[k] = origin[len - 1 - k];
            end
            history.push_back(strip);
            if (history.size() > 16) void'(history.pop_front());
            count = ($urandom_range(0, 11) == 0) ? $urandom_range(1, len) : len;
            send_strip(strip, count, force_start || ($urandom_range(0, 19) == 0));
            sent += count;
            force_start = (count < len);
            if ($urandom_range(0, 39) == 0) drain_results();
         end
      end
   endtask

   always @(negedge clock) begin
      sink_tick <= sink_tick + 8'd1;
      case (sink_mode)
         SINK_ALWAYS: rsp_tready <= 1'b1;
         SINK_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
         SINK_SPARSE: rsp_tready <= (sink_tick[1:0] == 2'b00);
         default:     rsp_tready <= (sink_tick[5:4] != 2'b11);
      endcase
   end

   always @(posedge clock) begin : result_check
      strip_verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_verdicts.size() == 0) begin
            $display("%0t: transfer expected none, got strip_label %0d flags %b",
                     $time, rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = awaited_verdicts.pop_front();
            if (rsp_tdata !== want.label) begin
               $display("%0t: strip_label expected %0d, got %0d", $time, want.label, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser[0] !== want.flipped) begin
               $display("%0t: flipped expected %b, got %b", $time, want.flipped, rsp_tuser[0]);
               mismatch_count++;
            end
            if (rsp_tuser[1] !== want.is_new) begin
               $display("%0t: is_new expected %b, got %b", $time, want.is_new, rsp_tuser[1]);
               mismatch_count++;
            end
            if (rsp_tuser[2] !== want.table_full) begin
               $display("%0t: table_full expected %b, got %b",
                        $time, want.table_full, rsp_tuser[2]);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("strip_dedup_with_mirror_match_tb: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_length();
      test_mirror_match();
      test_length_clamp();
      test_start_discards_tail();
      test_length_change_mid_strip();
      test_table_full();
      test_random_strips();
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && awaited_verdicts.size() == 0) begin
         $display("strip_dedup_with_mirror_match_tb: PASS");
      end else begin
         $display("strip_dedup_with_mirror_match_tb: FAIL");
      end
      $finish;
   end

endmodule
